// ----- hdl/iral_pkg.sv -----
// Shared types, constants and helpers for the interval room allocator.
// No dependencies; imported by iral_ctrl, iral_dp and the top level.
`timescale 1ns / 1ps
package iral_pkg;

    localparam int C_MAX_CUSTOMERS = 64;
    localparam int C_DEPTH         = 64;
    localparam int C_IDX_W         = 6;
    localparam int C_CNT_W         = 7;
    localparam int C_TIME_W        = 30;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PICK,
        S_REL,
        S_ASSIGN,
        S_ORD,
        S_OLD
    } t_state;

    typedef struct packed {
        logic idx_clr;
        logic pick_en;
        logic rel_en;
        logic assign_en;
        logic out_load;
        logic set_clear;
    } t_cmd;

    typedef struct packed {
        logic in_acc;
        logic in_last;
        logic scan_done;
        logic step_last;
        logic out_free;
        logic out_last;
    } t_status;

    // Lowest set bit of the free-room mask.
    function automatic logic [C_IDX_W-1:0] lowest_set(input logic [C_DEPTH-1:0] m);
        logic [C_IDX_W-1:0] b;
        b = '0;
        for (int i = C_DEPTH - 1; i >= 0; i--) begin
            if (m[i]) b = C_IDX_W'(i);
        end
        return b;
    endfunction

endpackage

// ----- hdl/iral_ctrl.sv -----
// Sequencer for the interval room allocator: load, pick, release, assign, report.
// Depends on iral_pkg.
`timescale 1ns / 1ps
module iral_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  iral_pkg::t_status i_sts,
    output iral_pkg::t_cmd   o_cmd,
    output logic             o_loading
);
    import iral_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_LOAD;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_loading = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_loading = 1'b1;
                if (i_sts.in_acc && i_sts.in_last) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick_en = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_REL;
                end
            end
            S_REL: begin
                o_cmd.rel_en = 1'b1;
                if (i_sts.scan_done) n_state = S_ASSIGN;
            end
            S_ASSIGN: begin
                o_cmd.assign_en = 1'b1;
                o_cmd.idx_clr   = 1'b1;
                n_state         = i_sts.step_last ? S_ORD : S_PICK;
            end
            S_ORD: n_state = S_OLD;
            S_OLD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.out_last) begin
                        o_cmd.set_clear = 1'b1;
                        n_state         = S_LOAD;
                    end else begin
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

endmodule

// ----- hdl/iral_dp.sv -----
// Datapath for the interval room allocator: interval stores, scan unit, room masks,
// output register. Depends on iral_pkg; driven by iral_ctrl commands.
`timescale 1ns / 1ps
module iral_dp #(
    parameter int MAX_CUSTOMERS = iral_pkg::C_MAX_CUSTOMERS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  iral_pkg::t_cmd                 i_cmd,
    input  logic                           i_in_acc,
    input  logic [iral_pkg::C_TIME_W-1:0]  i_arrival_time,
    input  logic [iral_pkg::C_TIME_W-1:0]  i_departure_time,
    input  logic                           i_out_stall,
    output logic                           o_scan_done,
    output logic                           o_step_last,
    output logic                           o_out_free,
    output logic                           o_out_last,
    output logic                           o_valid,
    output logic [iral_pkg::C_IDX_W-1:0]   o_customer_index,
    output logic [iral_pkg::C_CNT_W-1:0]   o_room_number,
    output logic [iral_pkg::C_CNT_W-1:0]   o_rooms_used,
    output logic                           o_overflow,
    output logic                           o_last_result
);
    import iral_pkg::*;

    logic [C_TIME_W-1:0] arr_mem  [C_DEPTH];
    logic [C_TIME_W-1:0] dep_mem  [C_DEPTH];
    logic [C_IDX_W-1:0]  room_mem [C_DEPTH];

    logic [C_TIME_W-1:0] r_arr_q, r_dep_q, r_min;
    logic [C_IDX_W-1:0]  r_room_q, r_pick, r_max, r_rd_idx;
    logic [C_CNT_W-1:0]  r_idx, r_count, r_step;
    logic                r_rd_vld, r_found, r_ovf, r_ovalid;
    logic [C_DEPTH-1:0]  r_placed, r_released, r_free;
    logic [C_IDX_W-1:0]  w_room;
    logic                w_scan;

    assign w_scan      = i_cmd.pick_en || i_cmd.rel_en;
    assign w_room      = lowest_set(r_free);
    assign o_scan_done = (r_idx == r_count) && !r_rd_vld;
    assign o_step_last = (r_step + 1'b1) == r_count;
    assign o_out_free  = !r_ovalid || !i_out_stall;
    assign o_out_last  = (r_idx + 1'b1) == r_count;
    assign o_valid     = r_ovalid;

    // Stores: one write port, one registered read at the scan address.
    always_ff @(posedge i_clk) begin
        if (i_in_acc && r_count < C_CNT_W'(MAX_CUSTOMERS)) begin
            arr_mem[r_count[C_IDX_W-1:0]] <= i_arrival_time;
            dep_mem[r_count[C_IDX_W-1:0]] <= i_departure_time;
        end
        if (i_cmd.assign_en) room_mem[r_pick] <= w_room;
        r_arr_q  <= arr_mem[r_idx[C_IDX_W-1:0]];
        r_dep_q  <= dep_mem[r_idx[C_IDX_W-1:0]];
        r_room_q <= room_mem[r_idx[C_IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_count    <= '0;
            r_step     <= '0;
            r_rd_vld   <= 1'b0;
            r_found    <= 1'b0;
            r_ovf      <= 1'b0;
            r_ovalid   <= 1'b0;
            r_placed   <= '0;
            r_released <= '0;
            r_free     <= '1;
            r_max      <= '0;
        end else begin
            if (i_in_acc) begin
                if (r_count < C_CNT_W'(MAX_CUSTOMERS)) r_count <= r_count + 1'b1;
                else                                   r_ovf   <= 1'b1;
            end
            // Scan: issue one address a cycle, consume the registered data in the next cycle.
            if (w_scan && r_idx != r_count) begin
                r_idx    <= r_idx + 1'b1;
                r_rd_vld <= 1'b1;
                r_rd_idx <= r_idx[C_IDX_W-1:0];
            end else begin
                r_rd_vld <= 1'b0;
            end
            if (i_cmd.pick_en && r_rd_vld && !r_placed[r_rd_idx]
                && (!r_found || r_arr_q < r_min)) begin
                r_found <= 1'b1;
                r_pick  <= r_rd_idx;
                r_min   <= r_arr_q;
            end
            if (i_cmd.rel_en && r_rd_vld && r_placed[r_rd_idx]
                && !r_released[r_rd_idx] && r_dep_q < r_min) begin
                r_released[r_rd_idx] <= 1'b1;
                r_free[r_room_q]     <= 1'b1;
            end
            if (i_cmd.assign_en) begin
                r_free[w_room]   <= 1'b0;
                r_placed[r_pick] <= 1'b1;
                r_step           <= r_step + 1'b1;
                if (w_room > r_max) r_max <= w_room;
            end
            if (i_cmd.idx_clr) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
                r_found  <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_ovalid         <= 1'b1;
                o_customer_index <= r_idx[C_IDX_W-1:0];
                o_room_number    <= {1'b0, r_room_q} + 1'b1;
                o_rooms_used     <= {1'b0, r_max} + 1'b1;
                o_overflow       <= r_ovf;
                o_last_result    <= o_out_last;
                r_idx            <= r_idx + 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.set_clear) begin
                r_count    <= '0;
                r_step     <= '0;
                r_ovf      <= 1'b0;
                r_placed   <= '0;
                r_released <= '0;
                r_free     <= '1;
                r_max      <= '0;
            end
        end
    end

endmodule

// ----- hdl/interval_room_allocation_lowest_free_core.sv -----
// Top level of the interval room allocator (greedy interval partitioning).
// Depends on iral_pkg, iral_ctrl and iral_dp.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  input   | in        | i_valid / o_stall  | arrival_time, departure_time, last_customer
//  result  | out       | o_valid / i_stall  | customer_index, room_number, rooms_used,
//          |           |                    | overflow, last_result
//
// Flow: loading takes one transaction per cycle. After the last one, each of the
//   n customers costs two scans of the stores (one read port) plus the S_ASSIGN
//   state; results then leave one at a time through the S_ORD and S_OLD states.
// Reset: synchronous, active low; clears the masks, counters and output valid.
// Stalls: o_stall is high from the last input until the final result is loaded;
//   i_stall holds the output register and the sequencer waits on it.
`timescale 1ns / 1ps
module interval_room_allocation_lowest_free_core #(
    parameter int MAX_CUSTOMERS = iral_pkg::C_MAX_CUSTOMERS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [iral_pkg::C_TIME_W-1:0] i_arrival_time,
    input  logic [iral_pkg::C_TIME_W-1:0] i_departure_time,
    input  logic                          i_last_customer,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [iral_pkg::C_IDX_W-1:0]  o_customer_index,
    output logic [iral_pkg::C_CNT_W-1:0]  o_room_number,
    output logic [iral_pkg::C_CNT_W-1:0]  o_rooms_used,
    output logic                          o_overflow,
    output logic                          o_last_result
);
    import iral_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;
    logic    w_loading;
    logic    w_in_acc;
    logic    w_scan_done;
    logic    w_step_last;
    logic    w_out_free;
    logic    w_out_last;

    // Accept input only while loading.
    assign o_stall  = !w_loading;
    assign w_in_acc = i_valid && w_loading;

    // Gather the status bits for the sequencer in one place.
    assign w_sts = {w_in_acc, i_last_customer, w_scan_done, w_step_last,
                    w_out_free, w_out_last};

    iral_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_loading (w_loading)
    );

    iral_dp #(
        .MAX_CUSTOMERS (MAX_CUSTOMERS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_in_acc         (w_in_acc),
        .i_arrival_time   (i_arrival_time),
        .i_departure_time (i_departure_time),
        .i_out_stall      (i_stall),
        .o_scan_done      (w_scan_done),
        .o_step_last      (w_step_last),
        .o_out_free       (w_out_free),
        .o_out_last       (w_out_last),
        .o_valid          (o_valid),
        .o_customer_index (o_customer_index),
        .o_room_number    (o_room_number),
        .o_rooms_used     (o_rooms_used),
        .o_overflow       (o_overflow),
        .o_last_result    (o_last_result)
    );

endmodule
